FILE: rtl/sfal_pkg.sv
`timescale 1ns / 1ps

package sfal_pkg;

   localparam int NUM_LISTS     = 5;
   localparam int LIST_CAPACITY = 16;
   localparam int ADDR_WIDTH    = 32;

   localparam int MEM_DEPTH = NUM_LISTS * LIST_CAPACITY;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);
   localparam int CNT_W     = $clog2(LIST_CAPACITY + 1);
   localparam int POS_W     = $clog2(LIST_CAPACITY);

   typedef enum logic [2:0] {
      OP_INSERT   = 3'd0,
      OP_DELETE   = 3'd1,
      OP_FIRST    = 3'd2,
      OP_NEXT     = 3'd3,
      OP_PREVIOUS = 3'd4,
      OP_EMPTY    = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_ZERO      = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_INS_CHK,
      S_INS_CMP,
      S_FIND_RD,
      S_FIND_CMP,
      S_DEL_CHK,
      S_DEL_WR,
      S_FIRST_RD,
      S_RES_CAP,
      S_FIN
   } state_type;

   // read position relative to the working index
   typedef enum logic [1:0] {
      RD_IDX,
      RD_DEC,
      RD_INC
   } rd_sel_type;

   typedef enum logic {
      WD_ADDR,
      WD_RDDATA
   } wr_sel_type;

   typedef enum logic {
      RES_RDDATA,
      RES_PREV
   } res_sel_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_CLEAR,
      IDX_COUNT,
      IDX_INC,
      IDX_DEC
   } idx_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef struct packed {
      logic        capture;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        wr_en;
      wr_sel_type  wr_sel;
      idx_op_type  idx_op;
      cnt_op_type  cnt_op;
      logic        save_prev;
      logic        res_load;
      res_sel_type res_sel;
      logic        st_load;
      status_type  st_code;
      logic        rsp_load;
   } ctl_cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       list_bad;
      logic       addr_zero;
      logic       cnt_zero;
      logic       cnt_full;
      logic       idx_zero;
      logic       idx_end;   // idx >= count
      logic       idx_last;  // idx + 1 >= count
      logic       rd_ge;     // read entry >= operand
      logic       rd_eq;     // read entry == operand
   } dp_stat_type;

endpackage

FILE: rtl/sorted_free_address_lists_top.sv
`timescale 1ns / 1ps

// Sorted free address lists: NUM_LISTS lists, one per size class, each holding up
// to LIST_CAPACITY block addresses in ascending order in one shared entry memory
// (one write port, one registered read port) with a reset-cleared count per list.
// Each request names an opcode (insert, delete, first, next, previous, empty
// test), a list and an address, and yields exactly one response carrying the
// found address (0 = none), the list's empty flag after the operation and a
// status (ok, not found, list full, address zero rejected). Insert places the
// address ahead of equal entries; delete, next and previous act on the first
// equal entry. One request is worked at a time; the search and the shift walk
// the list one entry at a time through the memory's single read port (read,
// then compare or write). The response sits in an output register, so a new
// request is taken while the previous response still waits. No clearing pass
// is needed after reset: entries beyond a list's count are never read.

module sorted_free_address_lists_top
   import sfal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [2:0]  req_list_index,
   input  logic [31:0] req_block_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result_address,
   output logic        rsp_list_empty,
   output logic [1:0]  rsp_status
);

   // controller <-> datapath
   ctl_cmd_type cmd;
   dp_stat_type stat;

   // sequencer: request/response transfer handshake and per-op step order
   sfal_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // operand registers, list counts, entry memory and response register
   sfal_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_opcode         (req_opcode),
      .req_list_index     (req_list_index),
      .req_block_address  (req_block_address),
      .rsp_result_address (rsp_result_address),
      .rsp_list_empty     (rsp_list_empty),
      .rsp_status         (rsp_status),
      .cmd                (cmd),
      .stat               (stat)
   );

endmodule

FILE: rtl/sfal_ram.sv
`timescale 1ns / 1ps

module sfal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 80
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/sfal_ctl.sv
`timescale 1ns / 1ps

module sfal_ctl
   import sfal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output ctl_cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.rd_sel    = RD_IDX;
      cmd.wr_sel    = WD_ADDR;
      cmd.idx_op    = IDX_HOLD;
      cmd.cnt_op    = CNT_HOLD;
      cmd.res_sel   = RES_RDDATA;
      cmd.st_code   = ST_OK;
      req_ready     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end

         S_CHECK: begin
            if (stat.list_bad) begin
               cmd.st_load = 1'b1;
               cmd.st_code = ST_NOT_FOUND;
               state_in    = S_FIN;
            end else if (stat.addr_zero && (stat.op == OP_INSERT || stat.op == OP_DELETE ||
                                            stat.op == OP_NEXT || stat.op == OP_PREVIOUS)) begin
               cmd.st_load = 1'b1;
               cmd.st_code = ST_ZERO;
               state_in    = S_FIN;
            end else begin
               case (stat.op)
                  OP_INSERT: begin
                     if (stat.cnt_full) begin
                        cmd.st_load = 1'b1;
                        cmd.st_code = ST_FULL;
                        state_in    = S_FIN;
                     end else begin
                        cmd.idx_op = IDX_COUNT;
                        state_in   = S_INS_CHK;
                     end
                  end
                  OP_DELETE, OP_NEXT, OP_PREVIOUS: begin
                     cmd.idx_op = IDX_CLEAR;
                     state_in   = S_FIND_RD;
                  end
                  OP_FIRST: begin
                     cmd.idx_op = IDX_CLEAR;
                     state_in   = stat.cnt_zero ? S_FIN : S_FIRST_RD;
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end

         // insert: walk down from the tail, moving entries >= operand up one slot
         S_INS_CHK: begin
            if (stat.idx_zero) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WD_ADDR;
               cmd.cnt_op = CNT_INC;
               state_in   = S_FIN;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_DEC;
               state_in   = S_INS_CMP;
            end
         end

         S_INS_CMP: begin
            cmd.wr_en = 1'b1;
            if (stat.rd_ge) begin
               cmd.wr_sel = WD_RDDATA;
               cmd.idx_op = IDX_DEC;
               state_in   = S_INS_CHK;
            end else begin
               cmd.wr_sel = WD_ADDR;
               cmd.cnt_op = CNT_INC;
               state_in   = S_FIN;
            end
         end

         // linear search for the first equal entry
         S_FIND_RD: begin
            if (stat.idx_end) begin
               cmd.st_load = 1'b1;
               cmd.st_code = ST_NOT_FOUND;
               state_in    = S_FIN;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX;
               state_in   = S_FIND_CMP;
            end
         end

         S_FIND_CMP: begin
            if (stat.rd_eq) begin
               case (stat.op)
                  OP_DELETE: begin
                     state_in = S_DEL_CHK;
                  end
                  OP_NEXT: begin
                     if (stat.idx_last) begin
                        state_in = S_FIN;
                     end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_INC;
                        state_in   = S_RES_CAP;
                     end
                  end
                  default: begin
                     cmd.res_load = !stat.idx_zero;
                     cmd.res_sel  = RES_PREV;
                     state_in     = S_FIN;
                  end
               endcase
            end else begin
               cmd.save_prev = 1'b1;
               cmd.idx_op    = IDX_INC;
               state_in      = S_FIND_RD;
            end
         end

         // delete: pull the following entries down one slot
         S_DEL_CHK: begin
            if (stat.idx_last) begin
               cmd.cnt_op = CNT_DEC;
               state_in   = S_FIN;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_INC;
               state_in   = S_DEL_WR;
            end
         end

         S_DEL_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WD_RDDATA;
            cmd.idx_op = IDX_INC;
            state_in   = S_DEL_CHK;
         end

         S_FIRST_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IDX;
            state_in   = S_RES_CAP;
         end

         S_RES_CAP: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_RDDATA;
            state_in     = S_FIN;
         end

         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/sfal_dp.sv
`timescale 1ns / 1ps

module sfal_dp
   import sfal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [2:0]  req_opcode,
   input  logic [2:0]  req_list_index,
   input  logic [31:0] req_block_address,
   output logic [31:0] rsp_result_address,
   output logic        rsp_list_empty,
   output logic [1:0]  rsp_status,
   input  ctl_cmd_type cmd,
   output dp_stat_type stat
);

   opcode_type            op_ff, op_in;
   logic [2:0]            list_ff, list_in;
   logic [ADDR_WIDTH-1:0] addr_ff, addr_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [ADDR_WIDTH-1:0] prev_ff, prev_in;
   logic [ADDR_WIDTH-1:0] res_ff, res_in;
   status_type            st_ff, st_in;
   logic [CNT_W-1:0]      count_ff [NUM_LISTS];
   logic [CNT_W-1:0]      count_in [NUM_LISTS];
   logic [31:0]           rsp_addr_ff, rsp_addr_in;
   logic                  rsp_empty_ff, rsp_empty_in;
   logic [1:0]            rsp_st_ff, rsp_st_in;

   logic [CNT_W-1:0]      cur_count;
   logic                  list_bad;
   logic [CNT_W-1:0]      idx_inc, idx_dec, rd_idx;
   logic [MEM_AW-1:0]     row_base, mem_rd_addr, mem_wr_addr;
   logic [ADDR_WIDTH-1:0] mem_wr_data, mem_rd_data;

   assign list_bad = int'(list_ff) >= NUM_LISTS;

   always_comb begin
      cur_count = '0;
      for (int k = 0; k < NUM_LISTS; k++) begin
         if (int'(list_ff) == k) begin
            cur_count = count_ff[k];
         end
      end
   end

   // entry memory addressing: list row plus position in the row
   assign idx_inc  = idx_ff + 1'b1;
   assign idx_dec  = idx_ff - 1'b1;
   assign row_base = MEM_AW'(int'(list_ff) * LIST_CAPACITY);

   always_comb begin
      case (cmd.rd_sel)
         RD_DEC:  rd_idx = idx_dec;
         RD_INC:  rd_idx = idx_inc;
         default: rd_idx = idx_ff;
      endcase
   end

   assign mem_rd_addr = row_base + MEM_AW'(rd_idx[POS_W-1:0]);
   assign mem_wr_addr = row_base + MEM_AW'(idx_ff[POS_W-1:0]);
   assign mem_wr_data = (cmd.wr_sel == WD_RDDATA) ? mem_rd_data : addr_ff;

   sfal_ram #(
      .WIDTH (ADDR_WIDTH),
      .DEPTH (MEM_DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      stat.op        = op_ff;
      stat.list_bad  = list_bad;
      stat.addr_zero = (addr_ff == '0);
      stat.cnt_zero  = (cur_count == '0);
      stat.cnt_full  = (int'(cur_count) >= LIST_CAPACITY);
      stat.idx_zero  = (idx_ff == '0);
      stat.idx_end   = (idx_ff >= cur_count);
      stat.idx_last  = (idx_inc >= cur_count);
      stat.rd_ge     = (mem_rd_data >= addr_ff);
      stat.rd_eq     = (mem_rd_data == addr_ff);
   end

   always_comb begin
      op_in        = op_ff;
      list_in      = list_ff;
      addr_in      = addr_ff;
      idx_in       = idx_ff;
      prev_in      = prev_ff;
      res_in       = res_ff;
      st_in        = st_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_st_in    = rsp_st_ff;

      if (cmd.capture) begin
         op_in   = opcode_type'(req_opcode);
         list_in = req_list_index;
         addr_in = ADDR_WIDTH'(req_block_address);
         res_in  = '0;
         st_in   = ST_OK;
      end

      case (cmd.idx_op)
         IDX_CLEAR: idx_in = '0;
         IDX_COUNT: idx_in = cur_count;
         IDX_INC:   idx_in = idx_inc;
         IDX_DEC:   idx_in = idx_dec;
         default:   idx_in = idx_ff;
      endcase

      if (cmd.save_prev) begin
         prev_in = mem_rd_data;
      end
      if (cmd.res_load) begin
         res_in = (cmd.res_sel == RES_PREV) ? prev_ff : mem_rd_data;
      end
      if (cmd.st_load) begin
         st_in = cmd.st_code;
      end

      if (cmd.rsp_load) begin
         rsp_addr_in  = 32'(res_ff);
         rsp_empty_in = list_bad || (cur_count == '0);
         rsp_st_in    = st_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_LISTS; k++) begin
         count_in[k] = count_ff[k];
         if (int'(list_ff) == k) begin
            case (cmd.cnt_op)
               CNT_INC: count_in[k] = count_ff[k] + 1'b1;
               CNT_DEC: count_in[k] = count_ff[k] - 1'b1;
               default: count_in[k] = count_ff[k];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_LISTS; k++) begin
            count_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < NUM_LISTS; k++) begin
            count_ff[k] <= count_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      list_ff      <= list_in;
      addr_ff      <= addr_in;
      idx_ff       <= idx_in;
      prev_ff      <= prev_in;
      res_ff       <= res_in;
      st_ff        <= st_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_st_ff    <= rsp_st_in;
   end

   assign rsp_result_address = rsp_addr_ff;
   assign rsp_list_empty     = rsp_empty_ff;
   assign rsp_status         = rsp_st_ff;

   a_wr_valid_list: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> !list_bad)
      else $error("entry write to a nonexistent list");

   a_rd_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> (int'(mem_rd_addr) < MEM_DEPTH))
      else $error("entry read beyond memory depth");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      int'(cur_count) <= LIST_CAPACITY)
      else $error("list count above capacity");

   a_cnt_inc: assert property (@(posedge clock) disable iff (reset)
      (cmd.cnt_op == CNT_INC) |=> (int'(cur_count) == int'($past(cur_count)) + 1))
      else $error("insert did not grow the list by one");

endmodule
